// File: hdl/wsdf_pkg.sv
// Package for the WebSocket frame deframer: parse phase codes, header
// constants and the packed result type. No dependencies.
package wsdf_pkg;

  localparam int LenW = 64;
  localparam int KeyW = 32;

  // Parse phase codes.
  localparam logic [2:0] PH_HDR1 = 3'd0;
  localparam logic [2:0] PH_HDR2 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_MASK = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [2:0] EXT16_LEFT = 3'd1;
  localparam logic [2:0] EXT64_LEFT = 3'd7;
  localparam logic [3:0] OP_CLOSE = 4'h8;

  typedef struct packed {
    logic       was_masked;
    logic       close_frame;
    logic [3:0] frame_opcode;
    logic       fin_flag;
    logic       payload_valid;
    logic       frame_done;
    logic [7:0] payload_byte;
  } wsdf_res_t;

endpackage

// File: hdl/websocket_frame_deframer_top.sv
// Channel  | Handshake          | Payload
// in       | in_tvalid/tready   | in_tdata[7:0] rx_byte
// out      | out_tvalid/tready  | out_tdata[7:0] payload_byte, out_tlast frame_done,
//          |                    | out_tuser flags and opcode
// One byte is taken per clock unless the output stalls; the parse state, and the result
// register when that byte yields a result, are updated at the edge that accepts it, so
// throughput is one byte a cycle. A result appears in the cycle after its byte. The
// result register is the stage between the sides: a new byte is taken while out_tready
// is high or the register is empty. Reset (rst_n low, synchronous) returns to the
// first header byte.
// Top level of the WebSocket frame deframer; depends on wsdf_pkg.
module websocket_frame_deframer_top
  import wsdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] payload_byte
  output logic       out_tlast,  // frame_done
  output logic [7:0] out_tuser   // [0] payload_valid, [1] fin_flag, [5:2] frame_opcode,
                                 // [6] close_frame, [7] was_masked
);

  logic [2:0]      phase_r, phase_nxt;
  logic [2:0]      ext_cnt_r, ext_cnt_nxt;
  logic [LenW-1:0] rem_r, rem_nxt;
  logic [KeyW-1:0] key_r, key_nxt;
  logic [1:0]      pos_r, pos_nxt;
  logic            mask_on_r, mask_on_nxt;
  logic [3:0]      opcode_r, opcode_nxt;
  logic            fin_r, fin_nxt;
  logic            out_valid_r, out_valid_nxt;
  wsdf_res_t       res_r, res_nxt;

  logic            in_fire;
  logic            emit;
  logic            emit_valid;
  logic            emit_done;
  logic [7:0]      emit_byte;
  logic [7:0]      key_byte;
  logic [6:0]      len7;
  logic [LenW-1:0] len_shift;
  logic [LenW-1:0] rem_dec;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign len7      = in_tdata[6:0];
  assign len_shift = {rem_r[LenW-9:0], in_tdata};
  assign rem_dec   = rem_r - LenW'(1);

  always_comb begin
    case (pos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    ext_cnt_nxt = ext_cnt_r;
    rem_nxt     = rem_r;
    key_nxt     = key_r;
    pos_nxt     = pos_r;
    mask_on_nxt = mask_on_r;
    opcode_nxt  = opcode_r;
    fin_nxt     = fin_r;
    emit        = 1'b0;
    emit_valid  = 1'b0;
    emit_done   = 1'b0;
    emit_byte   = 8'd0;
    case (phase_r)
      PH_HDR2: begin
        mask_on_nxt = in_tdata[7];
        if (len7 == LEN_EXT16) begin
          rem_nxt     = '0;
          ext_cnt_nxt = EXT16_LEFT;
          phase_nxt   = PH_EXT;
        end else if (len7 == LEN_EXT64) begin
          rem_nxt     = '0;
          ext_cnt_nxt = EXT64_LEFT;
          phase_nxt   = PH_EXT;
        end else begin
          rem_nxt = LenW'(len7);
          pos_nxt = 2'd0;
          if (in_tdata[7]) begin
            phase_nxt = PH_MASK;
          end else if (len7 == 7'd0) begin
            phase_nxt = PH_HDR1;
            emit      = 1'b1;
            emit_done = 1'b1;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_EXT: begin
        rem_nxt = len_shift;
        if (ext_cnt_r == 3'd0) begin
          pos_nxt = 2'd0;
          if (mask_on_r) begin
            phase_nxt = PH_MASK;
          end else if (len_shift == '0) begin
            phase_nxt = PH_HDR1;
            emit      = 1'b1;
            emit_done = 1'b1;
          end else begin
            phase_nxt = PH_DATA;
          end
        end else begin
          ext_cnt_nxt = ext_cnt_r - 3'd1;
        end
      end
      PH_MASK: begin
        // Four key bytes shift fully through the register, so no clear is needed.
        key_nxt = {key_r[KeyW-9:0], in_tdata};
        pos_nxt = pos_r + 2'd1;
        if (pos_r == 2'd3) begin
          if (rem_r == '0) begin
            phase_nxt = PH_HDR1;
            emit      = 1'b1;
            emit_done = 1'b1;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        pos_nxt    = pos_r + 2'd1;
        rem_nxt    = rem_dec;
        emit       = 1'b1;
        emit_valid = 1'b1;
        emit_byte  = mask_on_r ? (in_tdata ^ key_byte) : in_tdata;
        emit_done  = (rem_dec == '0);
        if (rem_dec == '0) begin
          phase_nxt = PH_HDR1;
        end
      end
      default: begin
        fin_nxt    = in_tdata[7];
        opcode_nxt = in_tdata[3:0];
        phase_nxt  = PH_HDR2;
      end
    endcase
  end

  always_comb begin
    res_nxt.payload_byte  = emit_byte;
    res_nxt.payload_valid = emit_valid;
    res_nxt.frame_done    = emit_done;
    res_nxt.fin_flag      = fin_r;
    res_nxt.frame_opcode  = opcode_r;
    res_nxt.close_frame   = emit_done && (opcode_r == OP_CLOSE);
    res_nxt.was_masked    = mask_on_nxt;
  end

  always_comb begin
    if (in_fire) begin
      out_valid_nxt = emit;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR1;
      ext_cnt_r   <= 3'd0;
      rem_r       <= '0;
      key_r       <= '0;
      pos_r       <= 2'd0;
      mask_on_r   <= 1'b0;
      opcode_r    <= 4'd0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        phase_r   <= phase_nxt;
        ext_cnt_r <= ext_cnt_nxt;
        rem_r     <= rem_nxt;
        key_r     <= key_nxt;
        pos_r     <= pos_nxt;
        mask_on_r <= mask_on_nxt;
        opcode_r  <= opcode_nxt;
        fin_r     <= fin_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r.payload_byte;
  assign out_tlast  = res_r.frame_done;
  assign out_tuser  = {res_r.was_masked, res_r.close_frame, res_r.frame_opcode,
                       res_r.fin_flag, res_r.payload_valid};

  // A result without payload is only ever the marker of an empty frame.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.payload_valid |-> res_r.frame_done)
    else $error("result without payload does not end a frame");

  a_close_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.close_frame |-> res_r.frame_done)
    else $error("close flag raised before the end of a frame");

  // The payload phase is never entered with nothing left to deliver.
  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> rem_r != '0)
    else $error("payload phase with zero length left");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled while the result register is empty");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && phase_r == PH_HDR1)
    else $error("reset did not clear the parser");

endmodule
